FILE: rtl/alne_pkg.sv
// Shared types and constants for the advertising local name extractor.
// Holds the channel item structs and the controller/datapath command and
// status structs. No dependencies.
package alne_pkg;

  localparam int NAME_STORE_DEFAULT = 64;

  typedef struct packed {
    logic [7:0] adv_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] name_byte;
    logic       name_last;
  } out_item_t;

  typedef struct packed {
    logic step;
    logic fetch;
    logic load_name;
    logic load_none;
  } ctl_cmd_t;

  typedef struct packed {
    logic emit;
    logic none_now;
    logic run_last;
  } dp_status_t;

endpackage

FILE: rtl/alne_stream_if.sv
// Valid/ready request channel carrying one item of a packed type.
// Depends on alne_pkg for the default item type.
interface alne_stream_if #(
  parameter type item_t = alne_pkg::in_item_t
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/alne_ctrl.sv
// Controller for the local name extractor: input handshake, replay
// sequencing and the output valid flag. Depends on alne_pkg.
module alne_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  alne_pkg::dp_status_t  st,
  output alne_pkg::ctl_cmd_t    cmd
);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_SEND  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.step      = 1'b0;
    cmd.fetch     = 1'b0;
    cmd.load_name = 1'b0;
    cmd.load_none = 1'b0;
    case (state)
      ST_RUN: begin
        in_ready      = out_free;
        cmd.step      = in_valid && out_free;
        cmd.load_none = cmd.step && st.none_now;
        if (cmd.step && st.emit) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (out_free) begin
          cmd.load_name = 1'b1;
          state_next    = st.run_last ? ST_RUN : ST_FETCH;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_name || cmd.load_none) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/alne_datapath.sv
// Datapath for the local name extractor: structure walker, name buffer
// memory and output register. Depends on alne_pkg.
module alne_datapath #(
  parameter int NAME_STORE = alne_pkg::NAME_STORE_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  alne_pkg::ctl_cmd_t   cmd,
  input  alne_pkg::in_item_t   in_item,
  output alne_pkg::dp_status_t st,
  output alne_pkg::out_item_t  out_item
);

  localparam int         CW        = $clog2(NAME_STORE);
  localparam logic [8:0] STORE_LIM = 9'(NAME_STORE);

  localparam logic [1:0] PH_LEN   = 2'd0;
  localparam logic [1:0] PH_TYPE  = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam logic [7:0] KIND_SHORT = 8'h08;
  localparam logic [7:0] KIND_FULL  = 8'h09;

  logic [1:0]    phase;
  logic [1:0]    phase_next;
  logic [7:0]    field_length;
  logic [7:0]    field_length_next;
  logic [7:0]    field_kind;
  logic [7:0]    field_kind_next;
  logic [7:0]    bytes_left;
  logic [7:0]    bytes_left_next;
  logic [CW-1:0] name_count;
  logic [CW-1:0] name_count_next;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] run_end;
  logic [7:0]    mem_q;
  logic [7:0]    name_store [NAME_STORE];

  logic [7:0]    bl_dec;
  logic          qualifies;
  logic          wr_en;
  logic          emit;
  logic          named;

  assign bl_dec    = bytes_left - 8'd1;
  assign qualifies = (field_kind == KIND_SHORT || field_kind == KIND_FULL) &&
                     (field_length >= 8'd2) &&
                     (({1'b0, field_length} - 9'd1) < STORE_LIM);

  always_comb begin
    phase_next        = phase;
    field_length_next = field_length;
    field_kind_next   = field_kind;
    bytes_left_next   = bytes_left;
    name_count_next   = name_count;
    wr_en             = 1'b0;
    emit              = 1'b0;
    case (phase)
      PH_LEN: begin
        if (in_item.adv_byte == 8'd0) begin
          phase_next      = PH_DONE;
          name_count_next = '0;
        end else begin
          field_length_next = in_item.adv_byte;
          bytes_left_next   = in_item.adv_byte;
          phase_next        = PH_TYPE;
        end
      end
      PH_TYPE: begin
        field_kind_next = in_item.adv_byte;
        name_count_next = '0;
        bytes_left_next = bl_dec;
        phase_next      = (bl_dec == 8'd0) ? PH_LEN : PH_VALUE;
      end
      PH_VALUE: begin
        wr_en           = qualifies;
        bytes_left_next = bl_dec;
        if (qualifies) begin
          name_count_next = name_count + CW'(1);
        end
        if (bl_dec == 8'd0) begin
          if (qualifies) begin
            emit       = 1'b1;
            phase_next = PH_DONE;
          end else begin
            name_count_next = '0;
            phase_next      = PH_LEN;
          end
        end
      end
      default: begin
      end
    endcase
    named = emit || (phase == PH_DONE && name_count != '0);
    if (in_item.final_byte) begin
      phase_next        = PH_LEN;
      field_length_next = 8'd0;
      field_kind_next   = 8'd0;
      bytes_left_next   = 8'd0;
      name_count_next   = '0;
    end
  end

  assign st.emit     = emit;
  assign st.none_now = in_item.final_byte && !named;
  assign st.run_last = (rd_idx == run_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEN;
      field_length <= 8'd0;
      field_kind   <= 8'd0;
      bytes_left   <= 8'd0;
      name_count   <= '0;
      rd_idx       <= '0;
      run_end      <= '0;
    end else begin
      if (cmd.step) begin
        phase        <= phase_next;
        field_length <= field_length_next;
        field_kind   <= field_kind_next;
        bytes_left   <= bytes_left_next;
        name_count   <= name_count_next;
        if (emit) begin
          rd_idx  <= '0;
          run_end <= name_count;
        end
      end
      if (cmd.load_name) begin
        rd_idx <= rd_idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && wr_en) begin
      name_store[name_count] <= in_item.adv_byte;
    end
    if (cmd.fetch) begin
      mem_q <= name_store[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_name) begin
      out_item.found     <= 1'b1;
      out_item.name_byte <= mem_q;
      out_item.name_last <= (rd_idx == run_end);
    end else if (cmd.load_none) begin
      out_item.found     <= 1'b0;
      out_item.name_byte <= 8'd0;
      out_item.name_last <= 1'b1;
    end
  end

endmodule

FILE: rtl/adv_local_name_extract.sv
// Top level of the advertising local name extractor.
// Joins alne_ctrl and alne_datapath; uses alne_pkg and alne_stream_if.
//
// channel  dir  payload                          accepted when
// adv      in   adv_byte[7:0], final_byte        adv.valid && adv.ready
// result   out  found, name_byte[7:0], name_last result.valid && result.ready
//
// Parsing takes one payload byte per cycle while the output register is free.
// Once a name structure completes, input is held while the name is replayed
// from the single-port buffer: each name byte is read, then loaded into the output.
// Reset (rst, synchronous) returns the walker to expecting a length byte.
// A stalled result holds in the output register; input then waits for it.
module adv_local_name_extract #(
  parameter int NAME_STORE = alne_pkg::NAME_STORE_DEFAULT
) (
  input logic           clk,
  input logic           rst,
  alne_stream_if.sink   adv,
  alne_stream_if.source result
);

  alne_pkg::ctl_cmd_t   cmd;
  alne_pkg::dp_status_t st;
  alne_pkg::out_item_t  out_item;

  alne_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (adv.valid),
    .in_ready  (adv.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .st        (st),
    .cmd       (cmd)
  );

  alne_datapath #(
    .NAME_STORE (NAME_STORE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_item  (adv.data),
    .st       (st),
    .out_item (out_item)
  );

  assign result.data = out_item;

`ifndef SYNTHESIS
  a_hold_after_name: assert property (@(posedge clk) disable iff (rst)
    cmd.step && st.emit |=> !adv.ready)
    else $error("input taken during name replay");

  a_none_result: assert property (@(posedge clk) disable iff (rst)
    cmd.step && st.none_now |=> result.valid && !result.data.found &&
                                result.data.name_last)
    else $error("missing not-found result");

  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.data.found |->
      result.data.name_byte == 8'd0 && result.data.name_last)
    else $error("malformed not-found result");
`endif

endmodule

FILE: tb/tb_top.sv
// Testbench for adv_local_name_extract: drives advertising payload bytes and checks
// every extracted name byte and no-name result against a built-in parser model.
// Depends on alne_pkg, alne_stream_if and the adv_local_name_extract RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NAME_CAP = alne_pkg::NAME_STORE_DEFAULT;
  localparam int ITEM_TARGET = 420;
  localparam int QUIET_FROM = 150;
  localparam int QUIET_TO = 260;
  localparam int DRAIN_CYCLES = 2 * NAME_CAP + 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [7:0] AD_SHORT_NAME = 8'h08;
  localparam logic [7:0] AD_FULL_NAME = 8'h09;

  typedef enum logic [1:0] {
    WALK_LEN,
    WALK_TYPE,
    WALK_VALUE,
    WALK_DONE
  } walk_phase_t;

  typedef struct {
    alne_pkg::in_item_t  item;
    bit                  typed;
    alne_pkg::out_item_t exp;
  } adv_row_t;

  logic clk = 1'b0;
  logic rst;

  alne_stream_if #(.item_t(alne_pkg::in_item_t)) adv_ch ();
  alne_stream_if #(.item_t(alne_pkg::out_item_t)) res_ch ();

  adv_local_name_extract #(.NAME_STORE(NAME_CAP)) dut (
    .clk(clk),
    .rst(rst),
    .adv(adv_ch),
    .result(res_ch)
  );

  adv_row_t            stim[$];
  alne_pkg::out_item_t due_names[$];
  bit                  cur_typed;
  alne_pkg::out_item_t cur_exp;
  bit                  quiet;
  int                  errors;
  int                  cycles;
  int                  bytes_taken;
  int                  payloads;
  int                  names_seen;
  int                  blanks_seen;
  int                  mark;
  alne_pkg::out_item_t want;
  alne_pkg::out_item_t got;

  walk_phase_t walk_ph;
  logic [7:0]  st_len;
  logic [7:0]  st_kind;
  logic [7:0]  st_left;
  logic [7:0]  name_buf[NAME_CAP];
  int          name_cnt;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void walk_ad_byte(logic [7:0] b, logic fin);
    int                  emitted;
    bit                  fits;
    bit                  named;
    alne_pkg::out_item_t r;
    emitted = 0;
    case (walk_ph)
      WALK_LEN: begin
        if (b == 8'h00) begin
          walk_ph = WALK_DONE;
          name_cnt = 0;
        end else begin
          st_len = b;
          st_left = b;
          walk_ph = WALK_TYPE;
        end
      end
      WALK_TYPE: begin
        st_kind = b;
        name_cnt = 0;
        st_left = st_left - 8'd1;
        walk_ph = (st_left == 8'd0) ? WALK_LEN : WALK_VALUE;
      end
      WALK_VALUE: begin
        fits = (st_kind == AD_SHORT_NAME || st_kind == AD_FULL_NAME) && st_len >= 8'd2 &&
               (int'(st_len) - 1) < NAME_CAP;
        if (fits && name_cnt < NAME_CAP) begin
          name_buf[name_cnt] = b;
          name_cnt++;
        end
        st_left = st_left - 8'd1;
        if (st_left == 8'd0) begin
          if (fits && name_cnt > 0) begin
            for (int k = 0; k < name_cnt; k++) begin
              r.found = 1'b1;
              r.name_byte = name_buf[k];
              r.name_last = (k + 1 == name_cnt);
              due_names.push_back(r);
            end
            emitted = name_cnt;
            walk_ph = WALK_DONE;
          end else begin
            name_cnt = 0;
            walk_ph = WALK_LEN;
          end
        end
      end
      default: ;
    endcase
    if (fin) begin
      named = (emitted > 0) || (walk_ph == WALK_DONE && name_cnt > 0);
      if (!named) begin
        r.found = 1'b0;
        r.name_byte = 8'h00;
        r.name_last = 1'b1;
        due_names.push_back(r);
      end
      walk_ph = WALK_LEN;
      st_len = 8'h00;
      st_kind = 8'h00;
      st_left = 8'h00;
      name_cnt = 0;
    end
  endfunction

  function automatic void add_row(logic [7:0] b, logic fin, bit typed, logic found_w,
                                  logic [7:0] byte_w);
    adv_row_t r;
    r.item.adv_byte = b;
    r.item.final_byte = fin;
    r.typed = typed;
    r.exp.found = found_w;
    r.exp.name_byte = byte_w;
    r.exp.name_last = 1'b1;
    stim.push_back(r);
  endfunction

  function automatic int pick_name_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return NAME_CAP - 1;
    if (r < 3) return $urandom_range(13, NAME_CAP - 2);
    return $urandom_range(1, 12);
  endfunction

  function automatic void add_payload();
    logic [7:0] body[$];
    logic [7:0] t;
    int         nlen;
    int         kind;
    int         ending;
    int         keep;
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 10)) body.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        kind = $urandom_range(0, 99);
        t = $urandom_range(0, 1) ? AD_FULL_NAME : AD_SHORT_NAME;
        if (kind < 40) begin
          nlen = pick_name_len();
        end else if (kind < 50) begin
          nlen = $urandom_range(NAME_CAP, NAME_CAP + 6);
        end else if (kind < 55) begin
          nlen = 0;
        end else begin
          nlen = $urandom_range(0, 8);
          t = 8'($urandom_range(0, 255));
          if (t == AD_SHORT_NAME || t == AD_FULL_NAME) t = t ^ 8'h10;
        end
        body.push_back(8'(nlen + 1));
        body.push_back(t);
        repeat (nlen) body.push_back(8'($urandom_range(0, 255)));
      end
      ending = $urandom_range(0, 99);
      if (ending < 15) begin
        body.push_back(8'h00);
      end
      if (ending < 60) begin
        repeat ($urandom_range(0, 3)) begin
          body.push_back(8'($urandom_range(0, 255)));
        end
      end else if (ending < 80 && body.size() > 1) begin
        keep = $urandom_range(1, body.size() - 1);
        while (body.size() > keep) void'(body.pop_back());
      end
    end
    for (int i = 0; i < body.size(); i++)
      add_row(body[i], i == body.size() - 1, 1'b0, 1'b0, 8'h00);
  endfunction

  always @(negedge clk)
    res_ch.ready <= !rst && (quiet || $urandom_range(0, 99) >= 13);

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
    if (!rst) begin
      if (adv_ch.valid && adv_ch.ready) begin
        mark = due_names.size();
        walk_ad_byte(adv_ch.data.adv_byte, adv_ch.data.final_byte);
        if (cur_typed) begin
          while (due_names.size() > mark) void'(due_names.pop_back());
          due_names.push_back(cur_exp);
        end
        if (adv_ch.data.final_byte) payloads++;
        bytes_taken++;
        quiet = (bytes_taken >= QUIET_FROM && bytes_taken < QUIET_TO);
      end
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (due_names.size() == 0) begin
          $error("result with nothing due: found=%0b name_byte=%02h name_last=%0b",
                 got.found, got.name_byte, got.name_last);
          errors++;
        end else begin
          want = due_names.pop_front();
          if (got.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, got.found);
            errors++;
          end
          if (got.name_byte !== want.name_byte) begin
            $error("name_byte: expected %02h, got %02h", want.name_byte, got.name_byte);
            errors++;
          end
          if (got.name_last !== want.name_last) begin
            $error("name_last: expected %0b, got %0b", want.name_last, got.name_last);
            errors++;
          end
          if (got.found && got.name_last) names_seen++;
          if (!got.found) blanks_seen++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    adv_ch.valid = 1'b0;
    adv_ch.data = '0;
    res_ch.ready = 1'b0;
    quiet = 1'b0;
    walk_ph = WALK_LEN;
    st_len = 8'h00;
    st_kind = 8'h00;
    st_left = 8'h00;
    name_cnt = 0;

    // zero length on the final byte, then a length byte that is the final byte
    add_row(8'h00, 1'b1, 1'b1, 1'b0, 8'h00);
    add_row(8'h05, 1'b1, 1'b1, 1'b0, 8'h00);
    // one-byte name ending exactly on the final byte
    add_row(8'h02, 1'b0, 1'b0, 1'b0, 8'h00);
    add_row(AD_FULL_NAME, 1'b0, 1'b0, 1'b0, 8'h00);
    add_row(8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF);
    // length-one name type skipped, then a short name, then an ignored byte
    add_row(8'h01, 1'b0, 1'b0, 1'b0, 8'h00);
    add_row(AD_FULL_NAME, 1'b0, 1'b0, 1'b0, 8'h00);
    add_row(8'h02, 1'b0, 1'b0, 1'b0, 8'h00);
    add_row(AD_SHORT_NAME, 1'b0, 1'b0, 1'b0, 8'h00);
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 8'h00);
    add_row(8'hAA, 1'b1, 1'b0, 1'b0, 8'h00);
    // oversized name cut short by the final byte
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, 8'h00);
    add_row(AD_FULL_NAME, 1'b0, 1'b0, 1'b0, 8'h00);
    add_row(8'h41, 1'b0, 1'b0, 1'b0, 8'h00);
    add_row(8'h42, 1'b1, 1'b1, 1'b0, 8'h00);
    // zero length after a flags structure
    add_row(8'h02, 1'b0, 1'b0, 1'b0, 8'h00);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, 8'h00);
    add_row(8'h06, 1'b0, 1'b0, 1'b0, 8'h00);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, 8'h00);
    add_row(8'h41, 1'b1, 1'b1, 1'b0, 8'h00);
    // other type ending on the final byte
    add_row(8'h02, 1'b0, 1'b0, 1'b0, 8'h00);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, 8'h00);
    add_row(8'hFF, 1'b1, 1'b1, 1'b0, 8'h00);

    while (stim.size() < ITEM_TARGET) add_payload();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < stim.size(); i++) begin
      while (!quiet && $urandom_range(0, 99) < 13) begin
        adv_ch.valid <= 1'b0;
        @(negedge clk);
      end
      adv_ch.valid <= 1'b1;
      adv_ch.data <= stim[i].item;
      cur_typed = stim[i].typed;
      cur_exp = stim[i].exp;
      @(posedge clk);
      while (!adv_ch.ready) @(posedge clk);
      @(negedge clk);
    end
    adv_ch.valid <= 1'b0;

    while (due_names.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d bytes in %0d payloads sent;", bytes_taken, payloads);
    $display("tb_top: %0d names and %0d no-name results checked", names_seen, blanks_seen);
    if (errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
